// ===== hdl/rgbg4fb_pkg.sv =====
`default_nettype none

package rgbg4fb_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int SCREEN_W_W = 11;
    localparam int AREA_W_W   = 11;
    localparam int COORD_W    = 12;
    localparam int ROW_W      = 11;
    localparam int Y_W        = 13;
    localparam int CHAN_W     = 8;
    localparam int GRAY_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int BADDR_W    = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_ENABLE  = 2'd2;

    localparam logic [SCREEN_W_W-1:0] SCREEN_WIDTH_RST  = 11'd540;
    localparam logic [SCREEN_W_W-1:0] SCREEN_HEIGHT_RST = 11'd960;
    localparam logic                  FLUSH_ENABLE_RST  = 1'b1;

    localparam logic [15:0] GRAY_KR = 16'd76;
    localparam logic [15:0] GRAY_KG = 16'd150;
    localparam logic [15:0] GRAY_KB = 16'd30;
    localparam logic [8:0]  GRAY_ROUND = 9'd8;
    localparam logic [GRAY_W-1:0] GRAY_MAX = 4'hF;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    function automatic logic [GRAY_W-1:0] gray4(
        input logic [CHAN_W-1:0] red,
        input logic [CHAN_W-1:0] green,
        input logic [CHAN_W-1:0] blue
    );
        logic [15:0] sum;
        logic [8:0]  q;
        sum = 16'(red) * GRAY_KR + 16'(green) * GRAY_KG + 16'(blue) * GRAY_KB;
        q   = ({1'b0, sum[15:8]} + GRAY_ROUND) >> 4;
        return (q > 9'(GRAY_MAX)) ? GRAY_MAX : q[GRAY_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rgb_to_gray4_framebuffer_writer.sv =====
`default_nettype none

// Converts a raster stream of RGB888 pixels to 4-bit gray and stores each one
// that lands on the screen, while flush is enabled, by read-modify-write into
// a packed 4bpp framebuffer held in an internal single-port-write,
// registered-read memory of ((MAX_WIDTH+1)/2)*MAX_HEIGHT bytes. One pixel is
// accepted per clock while o_stall is low; the result beat passes through the
// stage A, B and C registers and the output register. The rate is set by the
// framebuffer memory, which does one read and one write per cycle; a
// write-through bypass covers back-to-back pixels that hit the same byte.
// After reset the framebuffer is zeroed by a clearing pass over every byte,
// during which o_stall stays high; configuration writes are taken throughout.
module rgb_to_gray4_framebuffer_writer #(
    parameter int MAX_WIDTH  = rgbg4fb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rgbg4fb_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,

    input  wire logic                                   i_cfg_we,
    input  wire logic [rgbg4fb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [rgbg4fb_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    input  wire logic                                   i_valid,
    output      logic                                   o_stall,
    input  wire logic                                   i_first_pixel,
    input  wire logic signed [rgbg4fb_pkg::COORD_W-1:0] i_area_left,
    input  wire logic signed [rgbg4fb_pkg::COORD_W-1:0] i_area_top,
    input  wire logic [rgbg4fb_pkg::AREA_W_W-1:0]       i_area_width,
    input  wire logic [rgbg4fb_pkg::CHAN_W-1:0]         i_red,
    input  wire logic [rgbg4fb_pkg::CHAN_W-1:0]         i_green,
    input  wire logic [rgbg4fb_pkg::CHAN_W-1:0]         i_blue,

    output      logic                                   o_valid,
    input  wire logic                                   i_stall,
    output      logic                                   o_written,
    output      logic [rgbg4fb_pkg::BADDR_W-1:0]        o_byte_address,
    output      logic [rgbg4fb_pkg::BYTE_W-1:0]         o_byte_value,
    output      logic [rgbg4fb_pkg::GRAY_W-1:0]         o_gray_level
);

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int NW        = (CW + 2 > 12) ? CW + 2 : 12;
    localparam int XW        = NW + 1;
    localparam int YW        = rgbg4fb_pkg::Y_W;
    localparam int RW        = rgbg4fb_pkg::ROW_W;
    localparam int HW        = $clog2(MAX_HEIGHT + 1);
    localparam int PITCH_MAX = (MAX_WIDTH + 1) / 2;
    localparam int PW        = $clog2(PITCH_MAX + 1);
    localparam int FB_DEPTH  = PITCH_MAX * MAX_HEIGHT;
    localparam int AW        = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;
    localparam int SUMW      = ((HW + PW > XW - 1) ? HW + PW : XW - 1) + 1;
    localparam int GW        = rgbg4fb_pkg::GRAY_W;
    localparam int BW        = rgbg4fb_pkg::BYTE_W;
    localparam int OAW       = rgbg4fb_pkg::BADDR_W;

    // configuration
    logic [rgbg4fb_pkg::SCREEN_W_W-1:0] r_scr_w;
    logic [rgbg4fb_pkg::SCREEN_W_W-1:0] r_scr_h;
    logic                               r_flush;
    logic [XW-1:0]                      n_sw_eff;
    logic [XW-1:0]                      r_sw_eff;
    logic [YW-1:0]                      r_sh_eff;
    logic [PW-1:0]                      r_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= rgbg4fb_pkg::SCREEN_WIDTH_RST;
            r_scr_h <= rgbg4fb_pkg::SCREEN_HEIGHT_RST;
            r_flush <= rgbg4fb_pkg::FLUSH_ENABLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rgbg4fb_pkg::CFG_SCREEN_WIDTH:  r_scr_w <= i_cfg_data;
                rgbg4fb_pkg::CFG_SCREEN_HEIGHT: r_scr_h <= i_cfg_data;
                rgbg4fb_pkg::CFG_FLUSH_ENABLE:  r_flush <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign n_sw_eff = (XW'(r_scr_w) > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(r_scr_w);

    always_ff @(posedge i_clk) begin
        r_sw_eff <= n_sw_eff;
        r_sh_eff <= (YW'(r_scr_h) > YW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(r_scr_h);
        r_pitch  <= PW'((n_sw_eff + XW'(1)) >> 1);
    end

    // clearing pass
    rgbg4fb_pkg::t_state r_state;
    rgbg4fb_pkg::t_state n_state;
    logic [AW-1:0]       r_clr;
    logic                clr_last;
    logic                clearing;

    assign clr_last = (r_clr == AW'(FB_DEPTH - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rgbg4fb_pkg::ST_CLEAR: if (clr_last) n_state = rgbg4fb_pkg::ST_RUN;
            rgbg4fb_pkg::ST_RUN:   n_state = rgbg4fb_pkg::ST_RUN;
        endcase
    end

    always_comb begin
        clearing = 1'b0;
        unique case (r_state)
            rgbg4fb_pkg::ST_CLEAR: clearing = 1'b1;
            rgbg4fb_pkg::ST_RUN:   clearing = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rgbg4fb_pkg::ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) r_clr <= r_clr + AW'(1);
        end
    end

    // pipeline handshake
    logic r_a_valid, r_b_valid, r_c_valid, r_o_valid;
    logic a_adv, b_adv, c_adv;
    logic a_free, b_free, c_free, o_free;
    logic in_acc;

    assign o_free  = !r_o_valid || !i_stall;
    assign c_adv   = r_c_valid && o_free;
    assign c_free  = !r_c_valid || c_adv;
    assign b_adv   = r_b_valid && c_free;
    assign b_free  = !r_b_valid || b_adv;
    assign a_adv   = r_a_valid && b_free;
    assign a_free  = !r_a_valid || a_adv;
    assign o_stall = clearing || !a_free;
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_a_valid <= in_acc || (r_a_valid && !a_adv);
            r_b_valid <= a_adv || (r_b_valid && !b_adv);
            r_c_valid <= b_adv || (r_c_valid && !c_adv);
            r_o_valid <= c_adv || (r_o_valid && i_stall);
        end
    end

    // stage A: position counters, coordinates, gray
    logic [CW-1:0]    r_col, n_col, col_base;
    logic [RW-1:0]    r_row, n_row, row_base;
    logic [CW:0]      col_inc;
    logic [NW-1:0]    aw_ext, aw_eff;
    logic             row_wrap;
    logic signed [XW-1:0] r_a_x;
    logic signed [YW-1:0] r_a_y;
    logic [GW-1:0]    r_a_gray;

    always_comb begin
        col_base = i_first_pixel ? '0 : r_col;
        row_base = i_first_pixel ? '0 : r_row;
        col_inc  = {1'b0, col_base} + (CW+1)'(1);
        aw_ext   = NW'(i_area_width);
        priority if (aw_ext == '0)               aw_eff = NW'(1);
        else if (aw_ext > NW'(MAX_WIDTH))        aw_eff = NW'(MAX_WIDTH);
        else                                     aw_eff = aw_ext;
        row_wrap = (NW'(col_inc) >= aw_eff);
        n_col    = row_wrap ? '0 : col_inc[CW-1:0];
        n_row    = row_wrap ? row_base + RW'(1) : row_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_x    <= XW'(i_area_left) + $signed({{(XW-CW){1'b0}}, col_base});
            r_a_y    <= YW'(i_area_top) + $signed({{(YW-RW){1'b0}}, row_base});
            r_a_gray <= rgbg4fb_pkg::gray4(i_red, i_green, i_blue);
        end
    end

    // stage B: clip and byte address
    logic            x_ok, y_ok;
    logic [HW-1:0]   y_idx;
    logic [SUMW-1:0] addr_full;
    logic [AW-1:0]   r_b_addr;
    logic            r_b_we, r_b_odd;
    logic [GW-1:0]   r_b_gray;

    always_comb begin
        x_ok      = !r_a_x[XW-1] && (r_a_x < $signed(r_sw_eff));
        y_ok      = !r_a_y[YW-1] && (r_a_y < $signed(r_sh_eff));
        y_idx     = r_a_y[HW-1:0];
        addr_full = SUMW'(y_idx) * SUMW'(r_pitch) + SUMW'(r_a_x[XW-1:1]);
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_addr <= addr_full[AW-1:0];
            r_b_we   <= r_flush && x_ok && y_ok;
            r_b_odd  <= r_a_x[0];
            r_b_gray <= r_a_gray;
        end
    end

    // framebuffer memory
    logic [BW-1:0] r_mem [FB_DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [BW-1:0] mem_wdata;
    logic [BW-1:0] r_rd;
    logic          r_fwd_hit;
    logic [BW-1:0] r_fwd_data;
    logic          c_wr;
    logic [BW-1:0] old_byte, new_byte;

    logic [AW-1:0] r_c_addr;
    logic          r_c_we, r_c_odd;
    logic [GW-1:0] r_c_gray;

    assign c_wr      = c_adv && r_c_we;
    assign mem_we    = clearing || c_wr;
    assign mem_waddr = clearing ? r_clr : r_c_addr;
    assign mem_wdata = clearing ? '0 : new_byte;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (b_adv) r_rd <= r_mem[r_b_addr];
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_fwd_hit  <= mem_we && (mem_waddr == r_b_addr);
            r_fwd_data <= mem_wdata;
            r_c_addr   <= r_b_addr;
            r_c_we     <= r_b_we;
            r_c_odd    <= r_b_odd;
            r_c_gray   <= r_b_gray;
        end
    end

    // stage C: nibble merge and write back
    always_comb begin
        old_byte = r_fwd_hit ? r_fwd_data : r_rd;
        new_byte = r_c_odd ? {r_c_gray, old_byte[3:0]} : {old_byte[7:4], r_c_gray};
    end

    logic            r_o_written;
    logic [OAW-1:0]  r_o_addr;
    logic [BW-1:0]   r_o_value;
    logic [GW-1:0]   r_o_gray;

    always_ff @(posedge i_clk) begin
        if (c_adv) begin
            r_o_written <= r_c_we;
            r_o_addr    <= r_c_we ? OAW'(r_c_addr) : '0;
            r_o_value   <= r_c_we ? new_byte : '0;
            r_o_gray    <= r_c_gray;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_written      = r_o_written;
    assign o_byte_address = r_o_addr;
    assign o_byte_value   = r_o_value;
    assign o_gray_level   = r_o_gray;

`ifndef ASSERT_OFF
    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_state == rgbg4fb_pkg::ST_RUN))
        else $error("pixel beat accepted during framebuffer clear");

    a_pipe_empty_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !(r_a_valid || r_b_valid || r_c_valid || r_o_valid))
        else $error("pipeline busy during framebuffer clear");

    a_same_byte_forwarded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_wr && b_adv && (r_b_addr == r_c_addr)) |=> r_fwd_hit)
        else $error("back-to-back write to same byte not forwarded");

    a_dropped_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_written) |-> (r_o_addr == '0 && r_o_value == '0))
        else $error("dropped pixel reports nonzero address or value");
`endif

endmodule

`default_nettype wire

// ===== dv/rgb_to_gray4_framebuffer_writer_checker.sv =====
`timescale 1ns / 100ps

module rgb_to_gray4_framebuffer_writer_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    input  logic                                   i_cfg_we,
    input  logic [rgbg4fb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rgbg4fb_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    input  logic                                   i_px_valid,
    input  logic                                   i_px_stall,
    input  logic                                   i_first_pixel,
    input  logic signed [rgbg4fb_pkg::COORD_W-1:0] i_area_left,
    input  logic signed [rgbg4fb_pkg::COORD_W-1:0] i_area_top,
    input  logic [rgbg4fb_pkg::AREA_W_W-1:0]       i_area_width,
    input  logic [rgbg4fb_pkg::CHAN_W-1:0]         i_red,
    input  logic [rgbg4fb_pkg::CHAN_W-1:0]         i_green,
    input  logic [rgbg4fb_pkg::CHAN_W-1:0]         i_blue,

    input  logic                                   i_res_valid,
    input  logic                                   i_res_stall,
    input  logic                                   i_written,
    input  logic [rgbg4fb_pkg::BADDR_W-1:0]        i_byte_address,
    input  logic [rgbg4fb_pkg::BYTE_W-1:0]         i_byte_value,
    input  logic [rgbg4fb_pkg::GRAY_W-1:0]         i_gray_level,

    output int                                     o_fail_count,
    output int                                     o_pending
);

    localparam int MAX_W    = rgbg4fb_pkg::MAX_WIDTH_DEF;
    localparam int MAX_H    = rgbg4fb_pkg::MAX_HEIGHT_DEF;
    localparam int GW       = rgbg4fb_pkg::GRAY_W;
    localparam int BW       = rgbg4fb_pkg::BYTE_W;
    localparam int OAW      = rgbg4fb_pkg::BADDR_W;
    localparam int FB_BYTES = ((MAX_W + 1) / 2) * MAX_H;
    localparam int LUMA_R   = 76;
    localparam int LUMA_G   = 150;
    localparam int LUMA_B   = 30;
    localparam int ROW_MOD  = 1 << rgbg4fb_pkg::ROW_W;
    localparam int SHOW_MAX = 10;

    typedef struct packed {
        logic           written;
        logic [OAW-1:0] byte_address;
        logic [BW-1:0]  byte_value;
        logic [GW-1:0]  gray_level;
    } t_pixel_store;

    bit [BW-1:0]  fb_shadow [FB_BYTES];
    t_pixel_store pending_stores [$];
    int           disp_width;
    int           disp_height;
    bit           flush_on;
    int           col_cnt;
    int           row_cnt;
    int           shown;

    function automatic logic [GW-1:0] luma4(int r, int g, int b);
        int level;
        level = (((r * LUMA_R + g * LUMA_G + b * LUMA_B) >> 8) + 8) >> 4;
        return (level > int'(rgbg4fb_pkg::GRAY_MAX)) ? rgbg4fb_pkg::GRAY_MAX : GW'(level);
    endfunction

    function automatic t_pixel_store predict_pixel_store(
        logic first, int left, int top, int aw, int r, int g, int b
    );
        t_pixel_store st;
        int           sw;
        int           sh;
        int           x;
        int           y;
        int           addr;
        st            = '0;
        st.gray_level = luma4(r, g, b);
        sw = (disp_width > MAX_W) ? MAX_W : disp_width;
        sh = (disp_height > MAX_H) ? MAX_H : disp_height;
        if (aw == 0) aw = 1;
        if (aw > MAX_W) aw = MAX_W;
        if (first) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        x = left + col_cnt;
        y = top + row_cnt;
        if (flush_on && x >= 0 && y >= 0 && x < sw && y < sh) begin
            addr = y * ((sw + 1) / 2) + x / 2;
            if (x % 2 == 1) begin
                fb_shadow[addr][7:4] = st.gray_level;
            end else begin
                fb_shadow[addr][3:0] = st.gray_level;
            end
            st.written      = 1'b1;
            st.byte_address = OAW'(addr);
            st.byte_value   = fb_shadow[addr];
        end
        col_cnt++;
        if (col_cnt >= aw) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1) % ROW_MOD;
        end
        return st;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_store seen;
        t_pixel_store want;
        if (!i_rst_n) begin
            disp_width   = int'(rgbg4fb_pkg::SCREEN_WIDTH_RST);
            disp_height  = int'(rgbg4fb_pkg::SCREEN_HEIGHT_RST);
            flush_on     = rgbg4fb_pkg::FLUSH_ENABLE_RST;
            col_cnt      = 0;
            row_cnt      = 0;
            shown        = 0;
            o_fail_count = 0;
            pending_stores.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rgbg4fb_pkg::CFG_SCREEN_WIDTH:  disp_width  = int'(i_cfg_data);
                    rgbg4fb_pkg::CFG_SCREEN_HEIGHT: disp_height = int'(i_cfg_data);
                    rgbg4fb_pkg::CFG_FLUSH_ENABLE:  flush_on    = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_res_valid && !i_res_stall) begin
                seen = '{i_written, i_byte_address, i_byte_value, i_gray_level};
                if (pending_stores.size() == 0) begin
                    o_fail_count++;
                    if (shown < SHOW_MAX) begin
                        $display("%0t: unexpected result: wr=%0d addr=%0h byte=%0h gray=%0d",
                                 $time, seen.written, seen.byte_address,
                                 seen.byte_value, seen.gray_level);
                    end
                    shown++;
                end else begin
                    want = pending_stores.pop_front();
                    if (seen.written !== want.written ||
                        seen.byte_address !== want.byte_address ||
                        seen.byte_value !== want.byte_value ||
                        seen.gray_level !== want.gray_level) begin
                        o_fail_count++;
                        if (shown < SHOW_MAX) begin
                            $display("%0t: mismatch exp wr=%0d addr=%0h byte=%0h gray=%0d",
                                     $time, want.written, want.byte_address,
                                     want.byte_value, want.gray_level);
                            $display("%0t:          got wr=%0d addr=%0h byte=%0h gray=%0d",
                                     $time, seen.written, seen.byte_address,
                                     seen.byte_value, seen.gray_level);
                        end
                        shown++;
                    end
                end
            end
            if (i_px_valid && !i_px_stall) begin
                pending_stores.push_back(predict_pixel_store(
                    i_first_pixel, int'(i_area_left), int'(i_area_top), int'(i_area_width),
                    int'(i_red), int'(i_green), int'(i_blue)));
            end
        end
        o_pending = pending_stores.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int RANDOM_ITEMS = 700;
    localparam int IDLE_LIMIT   = 1_600_000;
    localparam int TAIL_CYCLES  = 32;
    localparam int PRESET_COUNT = 9;
    localparam int MAX_W        = rgbg4fb_pkg::MAX_WIDTH_DEF;
    localparam int MAX_H        = rgbg4fb_pkg::MAX_HEIGHT_DEF;
    localparam int CDW          = rgbg4fb_pkg::CFG_DATA_W;
    localparam int XYW          = rgbg4fb_pkg::COORD_W;
    localparam int AWW          = rgbg4fb_pkg::AREA_W_W;
    localparam int CHW          = rgbg4fb_pkg::CHAN_W;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BURSTY
    } t_stall_mode;

    logic                                  clk      = 1'b0;
    logic                                  rst_n    = 1'b0;
    logic                                  cfg_we   = 1'b0;
    logic [rgbg4fb_pkg::CFG_IDX_W-1:0]     cfg_idx  = rgbg4fb_pkg::CFG_SCREEN_WIDTH;
    logic [CDW-1:0]                        cfg_data = '0;

    logic                  px_valid = 1'b0;
    logic                  px_stall;
    logic                  px_first = 1'b0;
    logic signed [XYW-1:0] px_left  = '0;
    logic signed [XYW-1:0] px_top   = '0;
    logic [AWW-1:0]        px_width = '0;
    logic [CHW-1:0]        px_red   = '0;
    logic [CHW-1:0]        px_green = '0;
    logic [CHW-1:0]        px_blue  = '0;

    logic                              res_valid;
    logic                              res_stall = 1'b0;
    logic                              res_written;
    logic [rgbg4fb_pkg::BADDR_W-1:0]   res_byte_address;
    logic [rgbg4fb_pkg::BYTE_W-1:0]    res_byte_value;
    logic [rgbg4fb_pkg::GRAY_W-1:0]    res_gray_level;

    int          fail_count;
    int          pending;
    int          idle_cycles     = 0;
    int          burst_left      = 1;
    int          gap_max         = 0;
    int          items_sent      = 0;
    t_stall_mode stall_mode      = STALL_NONE;
    int          stall_mode_left = 0;
    int          stall_run_left  = 0;

    int preset_sw [PRESET_COUNT] = '{16, 1, 0, 5, 1024, 2047, 1025, 13, 24};
    int preset_sh [PRESET_COUNT] = '{8, 1, 3, 0, 1024, 2047, 7, 6, 10};
    bit preset_fe [PRESET_COUNT] = '{1, 1, 1, 1, 1, 1, 1, 0, 1};

    rgb_to_gray4_framebuffer_writer u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_valid        (px_valid),
        .o_stall        (px_stall),
        .i_first_pixel  (px_first),
        .i_area_left    (px_left),
        .i_area_top     (px_top),
        .i_area_width   (px_width),
        .i_red          (px_red),
        .i_green        (px_green),
        .i_blue         (px_blue),
        .o_valid        (res_valid),
        .i_stall        (res_stall),
        .o_written      (res_written),
        .o_byte_address (res_byte_address),
        .o_byte_value   (res_byte_value),
        .o_gray_level   (res_gray_level)
    );

    rgb_to_gray4_framebuffer_writer_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_px_valid     (px_valid),
        .i_px_stall     (px_stall),
        .i_first_pixel  (px_first),
        .i_area_left    (px_left),
        .i_area_top     (px_top),
        .i_area_width   (px_width),
        .i_red          (px_red),
        .i_green        (px_green),
        .i_blue         (px_blue),
        .i_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .i_written      (res_written),
        .i_byte_address (res_byte_address),
        .i_byte_value   (res_byte_value),
        .i_gray_level   (res_gray_level),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (stall_mode_left == 0) begin
            stall_mode      <= t_stall_mode'($urandom_range(0, 3));
            stall_mode_left <= $urandom_range(32, 400);
        end else begin
            stall_mode_left <= stall_mode_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  res_stall <= 1'b0;
            STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: res_stall <= ($urandom_range(0, 9) < 7);
            default: begin
                if (stall_run_left == 0) begin
                    res_stall      <= !res_stall;
                    stall_run_left <= $urandom_range(1, 12);
                end else begin
                    stall_run_left <= stall_run_left - 1;
                end
            end
        endcase
    end

    always @(posedge clk) begin
        if ((px_valid && !px_stall) || (res_valid && !res_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("rgb_to_gray4_framebuffer_writer test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // hold the beat until taken, then idle between bursts
    task automatic send_pixel(logic first, int left, int top, int aw, int r, int g, int b);
        int gap;
        px_valid <= 1'b1;
        px_first <= first;
        px_left  <= XYW'(left);
        px_top   <= XYW'(top);
        px_width <= AWW'(aw);
        px_red   <= CHW'(r);
        px_green <= CHW'(g);
        px_blue  <= CHW'(b);
        @(posedge clk);
        while (px_stall !== 1'b0) @(posedge clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                px_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        px_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic set_screen(int sw, int sh, bit fe);
        logic [CDW-1:0] flush_word;
        flush_word    = CDW'($urandom);
        flush_word[0] = fe;
        cfg_we   <= 1'b1;
        cfg_idx  <= rgbg4fb_pkg::CFG_SCREEN_WIDTH;
        cfg_data <= CDW'(sw);
        @(posedge clk);
        cfg_idx  <= rgbg4fb_pkg::CFG_SCREEN_HEIGHT;
        cfg_data <= CDW'(sh);
        @(posedge clk);
        cfg_idx  <= rgbg4fb_pkg::CFG_FLUSH_ENABLE;
        cfg_data <= flush_word;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic int pick_channel();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic send_area(int span_x, int span_y);
        int   aw;
        int   eff_w;
        int   npx;
        int   left;
        int   top;
        logic first;
        aw    = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 20);
        eff_w = (aw == 0) ? 1 : (aw > MAX_W) ? MAX_W : aw;
        npx   = (eff_w > 24) ? $urandom_range(1, 24) : eff_w * $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0) npx = $urandom_range(1, npx);
        left  = $urandom_range(0, span_x + 8) - 6;
        top   = $urandom_range(0, span_y + 6) - 4;
        for (int i = 0; i < npx; i++) begin
            first = (i == 0) || ($urandom_range(0, 39) == 0);
            send_pixel(first, left, top, aw, pick_channel(), pick_channel(), pick_channel());
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8)) begin
            send_pixel(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        int phase;
        int random_start;
        int phase_end;
        int sw;
        int sh;
        bit fe;

        repeat (7) @(posedge clk);
        rst_n   <= 1'b1;
        gap_max = 3;

        // reset screen settings: gray extremes, nibble packing, edges, width clamps
        send_pixel(1, 0, 0, 4, 0, 0, 0);
        send_pixel(0, 0, 0, 4, 255, 255, 255);
        send_pixel(0, 0, 0, 4, 255, 0, 0);
        send_pixel(0, 0, 0, 4, 0, 255, 0);
        send_pixel(0, 0, 0, 4, 0, 0, 255);
        send_pixel(1, -1, 0, 2, 12, 34, 56);
        send_pixel(0, -1, 0, 2, 200, 100, 50);
        send_pixel(1, 2047, -2048, 1, 1, 2, 3);
        send_pixel(1, -2048, 2047, 0, 128, 128, 128);
        send_pixel(0, 538, 958, 0, 90, 90, 90);
        send_pixel(1, 539, 959, 2047, 255, 255, 0);
        send_pixel(0, 539, 959, 2047, 0, 0, 0);
        send_pixel(1, 0, 0, 1024, 77, 77, 77);

        wait_drained();
        set_screen(540, 960, 1'b0);
        send_pixel(1, 0, 0, 4, 255, 255, 255);
        send_pixel(0, 0, 0, 4, 60, 70, 80);

        wait_drained();
        set_screen(2047, 2047, 1'b1);
        send_pixel(1, 1022, 1023, 2, 10, 20, 30);
        send_pixel(0, 1022, 1023, 2, 250, 250, 250);
        send_pixel(0, 1022, 1023, 2, 99, 99, 99);

        wait_drained();
        set_screen(0, 0, 1'b1);
        send_pixel(1, 0, 0, 1, 255, 255, 255);

        // one full row past the width clamp
        wait_drained();
        set_screen(1030, 12, 1'b1);
        for (int i = 0; i < 1030; i++) begin
            send_pixel(i == 0, -3, 10, 1100, pick_channel(), pick_channel(), pick_channel());
        end

        random_start = items_sent;
        phase        = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if (phase < PRESET_COUNT) begin
                sw = preset_sw[phase];
                sh = preset_sh[phase];
                fe = preset_fe[phase];
            end else begin
                sw = $urandom_range(1, 40);
                sh = $urandom_range(1, 20);
                fe = ($urandom_range(0, 4) != 0);
            end
            wait_drained();
            set_screen(sw, sh, fe);
            case ($urandom_range(0, 3))
                0:       gap_max = 0;
                1:       gap_max = 2;
                2:       gap_max = 6;
                default: gap_max = 30;
            endcase
            if (sw > MAX_W) sw = MAX_W;
            if (sh > MAX_H) sh = MAX_H;
            phase_end = items_sent + $urandom_range(60, 110);
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 6) == 0) begin
                    send_noise();
                end else begin
                    send_area(sw, sh);
                end
            end
            phase++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("rgb_to_gray4_framebuffer_writer test passed");
        end else begin
            $display("rgb_to_gray4_framebuffer_writer test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rgbg4fb_pkg.sv
hdl/rgb_to_gray4_framebuffer_writer.sv
dv/rgb_to_gray4_framebuffer_writer_checker.sv
dv/tb.sv
